// File: src/crgb_pkg.sv
// shared types, constants and codes for the clipped rgb565 to rgb888 writer
`timescale 1ns / 1ps

package crgb_pkg;

    // default panel sides
    localparam int PANEL_SHORT_SIDE_DEF = 320;
    localparam int PANEL_LONG_SIDE_DEF  = 480;

    // input opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BITMAP_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BITMAP_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_BYTES    = 3'd5;

    // panel commands
    localparam logic [7:0] CMD_COL_ADDR  = 8'h2A;
    localparam logic [7:0] CMD_ROW_ADDR  = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;

    // byte positions inside a window header
    localparam logic [3:0] HB_COL_CMD  = 4'd0;
    localparam logic [3:0] HB_XS_HI    = 4'd1;
    localparam logic [3:0] HB_XS_LO    = 4'd2;
    localparam logic [3:0] HB_XE_HI    = 4'd3;
    localparam logic [3:0] HB_XE_LO    = 4'd4;
    localparam logic [3:0] HB_ROW_CMD  = 4'd5;
    localparam logic [3:0] HB_YS_HI    = 4'd6;
    localparam logic [3:0] HB_YS_LO    = 4'd7;
    localparam logic [3:0] HB_YE_HI    = 4'd8;
    localparam logic [3:0] HB_YE_LO    = 4'd9;
    localparam logic [3:0] HB_WRITE    = 4'd10;

    // byte positions inside a pixel
    localparam logic [3:0] PB_RED   = 4'd0;
    localparam logic [3:0] PB_GREEN = 4'd1;
    localparam logic [3:0] PB_BLUE  = 4'd2;

    // work queue depth
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]         rotation;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [14:0]        bitmap_width;
        logic [14:0]        bitmap_height;
        logic               swap_bytes;
    } cfg_t;

    // one unit of work for the byte sender
    typedef struct packed {
        logic        is_hdr;
        logic [15:0] pixel;
        logic [15:0] xs;
        logic [15:0] xe;
        logic [15:0] ys;
        logic [15:0] ye;
    } work_t;

endpackage

// File: src/crgb_front.sv
// front end: takes items, clips the window, tracks raster position
`timescale 1ns / 1ps

module crgb_front import crgb_pkg::*; #(
    parameter int PANEL_SHORT_SIDE = PANEL_SHORT_SIDE_DEF,
    parameter int PANEL_LONG_SIDE  = PANEL_LONG_SIDE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tuser,
    input  logic        q_full,
    output logic        q_push,
    output work_t       q_entry
);

    localparam int MAX_SIDE = (PANEL_SHORT_SIDE > PANEL_LONG_SIDE) ?
                              PANEL_SHORT_SIDE : PANEL_LONG_SIDE;
    localparam int COORD_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

    logic [COORD_W-1:0] clip_xs_reg, clip_xs_next;
    logic [COORD_W-1:0] clip_xe_reg, clip_xe_next;
    logic [COORD_W-1:0] clip_ys_reg, clip_ys_next;
    logic [COORD_W-1:0] clip_ye_reg, clip_ye_next;
    logic [14:0]        src_col_reg, src_col_next;
    logic [14:0]        src_row_reg, src_row_next;
    logic               draw_reg, draw_next;

    logic signed [17:0] pw, ph, x, y, x2, y2, px, py;
    logic               accept, empty, off_panel, in_clip, col_wrap, row_wrap;
    logic [15:0]        pix_sw;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        pw = cfg.rotation[0] ? 18'(PANEL_LONG_SIDE) : 18'(PANEL_SHORT_SIDE);
        ph = cfg.rotation[0] ? 18'(PANEL_SHORT_SIDE) : 18'(PANEL_LONG_SIDE);
        x  = 18'(cfg.origin_x);
        y  = 18'(cfg.origin_y);
        x2 = x + $signed({3'b000, cfg.bitmap_width}) - 18'sd1;
        y2 = y + $signed({3'b000, cfg.bitmap_height}) - 18'sd1;
        empty     = (cfg.bitmap_width == '0) || (cfg.bitmap_height == '0);
        off_panel = (x >= pw) || (y >= ph) || (x2 < 0) || (y2 < 0);

        px = x + $signed({3'b000, src_col_reg});
        py = y + $signed({3'b000, src_row_reg});
        in_clip = (px >= $signed(18'(clip_xs_reg))) && (px <= $signed(18'(clip_xe_reg))) &&
                  (py >= $signed(18'(clip_ys_reg))) && (py <= $signed(18'(clip_ye_reg)));
        col_wrap = (16'(src_col_reg) + 16'd1) >= 16'(cfg.bitmap_width);
        row_wrap = (16'(src_row_reg) + 16'd1) >= 16'(cfg.bitmap_height);

        pix_sw = cfg.swap_bytes ? {s_tdata[7:0], s_tdata[15:8]} : s_tdata;

        clip_xs_next = clip_xs_reg;
        clip_xe_next = clip_xe_reg;
        clip_ys_next = clip_ys_reg;
        clip_ye_next = clip_ye_reg;
        src_col_next = src_col_reg;
        src_row_next = src_row_reg;
        draw_next    = draw_reg;
        q_push       = 1'b0;

        if (accept) begin
            if (s_tuser == OP_START) begin
                draw_next = 1'b0;
                if (!empty && !off_panel) begin
                    clip_xs_next = (x < 0) ? '0 : COORD_W'(x);
                    clip_ys_next = (y < 0) ? '0 : COORD_W'(y);
                    clip_xe_next = (x2 >= pw) ? COORD_W'(pw - 18'sd1) : COORD_W'(x2);
                    clip_ye_next = (y2 >= ph) ? COORD_W'(ph - 18'sd1) : COORD_W'(y2);
                    src_col_next = '0;
                    src_row_next = '0;
                    draw_next    = 1'b1;
                    q_push       = 1'b1;
                end
            end else if (draw_reg) begin
                if (col_wrap) begin
                    src_col_next = '0;
                    if (row_wrap) begin
                        src_row_next = '0;
                        draw_next    = 1'b0;
                    end else begin
                        src_row_next = src_row_reg + 15'd1;
                    end
                end else begin
                    src_col_next = src_col_reg + 15'd1;
                end
                q_push = in_clip;
            end
        end

        q_entry.is_hdr = (s_tuser == OP_START);
        q_entry.pixel  = pix_sw;
        q_entry.xs     = 16'(clip_xs_next);
        q_entry.xe     = 16'(clip_xe_next);
        q_entry.ys     = 16'(clip_ys_next);
        q_entry.ye     = 16'(clip_ye_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_xs_reg <= '0;
            clip_xe_reg <= '0;
            clip_ys_reg <= '0;
            clip_ye_reg <= '0;
            src_col_reg <= '0;
            src_row_reg <= '0;
            draw_reg    <= 1'b0;
        end else begin
            clip_xs_reg <= clip_xs_next;
            clip_xe_reg <= clip_xe_next;
            clip_ys_reg <= clip_ys_next;
            clip_ye_reg <= clip_ye_next;
            src_col_reg <= src_col_next;
            src_row_reg <= src_row_next;
            draw_reg    <= draw_next;
        end
    end

endmodule

// File: src/crgb_queue.sv
// short work queue between front end and byte sender
`timescale 1ns / 1ps

module crgb_queue import crgb_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  work_t push_entry,
    input  logic  pop,
    output work_t head,
    output logic  full,
    output logic  not_empty
);

    work_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: src/crgb_back.sv
// byte sender: turns queued work into panel link beats
`timescale 1ns / 1ps

module crgb_back import crgb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_not_empty,
    input  work_t      q_head,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tuser,
    output logic       m_tlast
);

    logic [3:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       user_reg, user_next;
    logic       last_reg, last_next;

    logic       load, at_end;
    logic [7:0] sel_byte;
    logic       sel_data;
    logic [4:0] r5, b5;
    logic [5:0] g6;

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    always_comb begin
        r5 = q_head.pixel[15:11];
        g6 = q_head.pixel[10:5];
        b5 = q_head.pixel[4:0];
        sel_byte = '0;
        sel_data = 1'b1;
        if (q_head.is_hdr) begin
            unique case (idx_reg)
                HB_COL_CMD: begin sel_byte = CMD_COL_ADDR; sel_data = 1'b0; end
                HB_XS_HI:   sel_byte = q_head.xs[15:8];
                HB_XS_LO:   sel_byte = q_head.xs[7:0];
                HB_XE_HI:   sel_byte = q_head.xe[15:8];
                HB_XE_LO:   sel_byte = q_head.xe[7:0];
                HB_ROW_CMD: begin sel_byte = CMD_ROW_ADDR; sel_data = 1'b0; end
                HB_YS_HI:   sel_byte = q_head.ys[15:8];
                HB_YS_LO:   sel_byte = q_head.ys[7:0];
                HB_YE_HI:   sel_byte = q_head.ye[15:8];
                HB_YE_LO:   sel_byte = q_head.ye[7:0];
                HB_WRITE:   begin sel_byte = CMD_MEM_WRITE; sel_data = 1'b0; end
                default:    sel_byte = '0;
            endcase
            at_end = (idx_reg == HB_WRITE);
        end else begin
            unique case (idx_reg)
                PB_RED:   sel_byte = {r5, r5[4:2]};
                PB_GREEN: sel_byte = {g6, g6[5:4]};
                PB_BLUE:  sel_byte = {b5, b5[4:2]};
                default:  sel_byte = '0;
            endcase
            at_end = (idx_reg == PB_BLUE);
        end

        load       = q_not_empty && (!valid_reg || m_tready);
        q_pop      = load && at_end;
        idx_next   = idx_reg;
        valid_next = valid_reg && !m_tready;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = sel_byte;
            user_next  = sel_data;
            last_next  = at_end;
            idx_next   = at_end ? '0 : idx_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

endmodule

// File: src/clipped_rgb565_to_rgb888_display_writer_core.sv
// top level of the clipped rgb565 to rgb888 panel writer
`timescale 1ns / 1ps

// draws an rgb565 bitmap onto a panel, clipped to the panel edges. a start beat
// (tuser 0) clips the configured bitmap to the panel and sends the column window
// (0x2a plus four address bytes), the row window (0x2b plus four bytes) and the
// memory write command 0x2c, eleven output beats in all; an empty or off-panel
// bitmap sends nothing. pixel beats (tuser 1) follow in raster order over the
// whole bitmap; each visible pixel is optionally byte-swapped and leaves as three
// data beats r, g, b widened to eight bits by bit replication. clipped pixels and
// pixels outside a drawing send nothing. the front end takes one input beat per
// cycle, unless the queue is full, into a four-entry work queue; the byte sender
// drains it at one output beat per cycle while m_tready is high. output m_tuser
// is high on data bytes, low on command bytes; m_tlast marks the final byte of
// each input beat. configuration must be written by the user only while no
// results are outstanding; the block itself does not enforce this.

module clipped_rgb565_to_rgb888_display_writer_core import crgb_pkg::*; #(
    parameter int PANEL_SHORT_SIDE = PANEL_SHORT_SIDE_DEF,
    parameter int PANEL_LONG_SIDE  = PANEL_LONG_SIDE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [15:0] pixel
    input  logic                  s_tuser,   // [0] opcode
    // output beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] out_byte
    output logic                  m_tuser,   // [0] is_data
    output logic                  m_tlast
);

    cfg_t  cfg_reg;
    logic  q_push, q_pop, q_full, q_not_empty;
    work_t q_entry, q_head;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rotation      <= '0;
            cfg_reg.origin_x      <= '0;
            cfg_reg.origin_y      <= '0;
            cfg_reg.bitmap_width  <= '0;
            cfg_reg.bitmap_height <= '0;
            cfg_reg.swap_bytes    <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ROTATION:      cfg_reg.rotation      <= cfg_wdata[1:0];
                REG_ORIGIN_X:      cfg_reg.origin_x      <= cfg_wdata;
                REG_ORIGIN_Y:      cfg_reg.origin_y      <= cfg_wdata;
                REG_BITMAP_WIDTH:  cfg_reg.bitmap_width  <= cfg_wdata[14:0];
                REG_BITMAP_HEIGHT: cfg_reg.bitmap_height <= cfg_wdata[14:0];
                REG_SWAP_BYTES:    cfg_reg.swap_bytes    <= cfg_wdata[0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // clipping and raster tracking
    crgb_front #(
        .PANEL_SHORT_SIDE (PANEL_SHORT_SIDE),
        .PANEL_LONG_SIDE  (PANEL_LONG_SIDE)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    // decouples intake from the byte-wide output lane
    crgb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .not_empty  (q_not_empty)
    );

    // one beat per cycle onto the link while m_tready is high
    crgb_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// File: src/crgb_checker.sv
// port-level checks for the panel writer, bound to the top level
`timescale 1ns / 1ps

module crgb_checker import crgb_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // a stalled beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("stalled output beat changed");

    // memory write command always closes a header
    a_write_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser && (m_tdata == CMD_MEM_WRITE) |-> m_tlast)
        else $error("memory write command without last");

    // a command byte with last can only be the memory write command
    a_last_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && !m_tuser |-> (m_tdata == CMD_MEM_WRITE))
        else $error("wrong command byte at end of header");

    // the column command is followed by address data, never another command
    a_col_then_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tuser && (m_tdata == CMD_COL_ADDR)
        |=> !m_tvalid || m_tuser)
        else $error("column command not followed by address data");

endmodule

bind clipped_rgb565_to_rgb888_display_writer_core crgb_checker u_crgb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
